// File: hdl/ust_pkg.sv
package ust_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned KIND_W        = 2;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned COUNT_W       = 5;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_DELETE,
      OP_LOOKUP
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_DUP    = 2'd1,
      ST_ABSENT = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_SHIFT,
      BK_RESP
   } back_state_type;

   typedef struct packed {
      op_type                    op;
      logic signed [VALUE_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

// File: hdl/ust_ram.sv
module ust_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ust_front.sv
module ust_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ust_pkg::KIND_W-1:0]       req_kind,
   input  logic signed [ust_pkg::VALUE_W-1:0] req_value,
   output ust_pkg::queue_out_type           q_out,
   input  logic                             q_pop
);

   ust_pkg::item_type slot_ff [2];
   ust_pkg::item_type slot_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;
   ust_pkg::op_type   op;

   always_comb begin
      case (req_kind)
         ust_pkg::KIND_INSERT: op = ust_pkg::OP_INSERT;
         ust_pkg::KIND_DELETE: op = ust_pkg::OP_DELETE;
         default:              op = ust_pkg::OP_LOOKUP;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (cnt_ff != 2'd0);

   always_comb begin
      slot_in.op    = op;
      slot_in.value = req_value;
      wr_ptr_in     = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in     = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in        = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.item  = slot_ff[rd_ptr_ff];

endmodule

// File: hdl/ust_back.sv
module ust_back #(
   parameter int unsigned DEPTH = ust_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ust_pkg::queue_out_type              q_out,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ust_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_found,
   output logic [ust_pkg::COUNT_W-1:0]         rsp_count
);

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(DEPTH + 1);
   localparam int unsigned EXT_W  = (FILL_W > ust_pkg::COUNT_W) ? FILL_W : ust_pkg::COUNT_W;
   localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(DEPTH);
   localparam logic [FILL_W-1:0] ONE_F   = FILL_W'(1);

   ust_pkg::back_state_type state_ff, state_in;
   ust_pkg::op_type         op_ff, op_in;
   logic signed [ust_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [FILL_W-1:0]       idx_ff, idx_in;
   logic [ADDR_W-1:0]       cmp_ff, cmp_in;
   logic [ADDR_W-1:0]       dst_ff, dst_in;
   logic                    pend_ff, pend_in;
   ust_pkg::status_type     status_ff, status_in;
   logic                    found_ff, found_in;

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ust_pkg::VALUE_W-1:0] wr_data;
   logic                        rd_en;
   logic [ADDR_W-1:0]           rd_addr;
   logic [ust_pkg::VALUE_W-1:0] rd_data;
   logic                        hit;
   logic [EXT_W-1:0]            fill_ext;

   ust_ram #(
      .WIDTH (ust_pkg::VALUE_W),
      .DEPTH (DEPTH),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign hit = pend_ff && (rd_data == value_ff);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      value_in  = value_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      cmp_in    = cmp_ff;
      dst_in    = dst_ff;
      pend_in   = pend_ff;
      status_in = status_ff;
      found_in  = found_ff;
      q_pop     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = dst_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[ADDR_W-1:0];
      case (state_ff)
         ust_pkg::BK_IDLE: begin
            if (q_out.valid) begin
               q_pop    = 1'b1;
               op_in    = q_out.item.op;
               value_in = q_out.item.value;
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = ust_pkg::BK_SCAN;
            end
         end
         ust_pkg::BK_SCAN: begin
            if (hit) begin
               found_in = 1'b1;
               pend_in  = 1'b0;
               case (op_ff)
                  ust_pkg::OP_INSERT: begin
                     status_in = ust_pkg::ST_DUP;
                     state_in  = ust_pkg::BK_RESP;
                  end
                  ust_pkg::OP_DELETE: begin
                     status_in = ust_pkg::ST_OK;
                     dst_in    = cmp_ff;
                     idx_in    = FILL_W'(cmp_ff) + ONE_F;
                     state_in  = ust_pkg::BK_SHIFT;
                  end
                  default: begin
                     status_in = ust_pkg::ST_OK;
                     state_in  = ust_pkg::BK_RESP;
                  end
               endcase
            end else if (idx_ff < fill_ff) begin
               rd_en   = 1'b1;
               cmp_in  = idx_ff[ADDR_W-1:0];
               idx_in  = idx_ff + ONE_F;
               pend_in = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               found_in = 1'b0;
               state_in = ust_pkg::BK_RESP;
               case (op_ff)
                  ust_pkg::OP_INSERT: begin
                     if (fill_ff < DEPTH_F) begin
                        wr_en     = 1'b1;
                        wr_addr   = fill_ff[ADDR_W-1:0];
                        wr_data   = value_ff;
                        fill_in   = fill_ff + ONE_F;
                        status_in = ust_pkg::ST_OK;
                     end else begin
                        status_in = ust_pkg::ST_FULL;
                     end
                  end
                  default: status_in = ust_pkg::ST_ABSENT;
               endcase
            end
         end
         ust_pkg::BK_SHIFT: begin
            if (pend_ff) begin
               wr_en  = 1'b1;
               dst_in = dst_ff + ADDR_W'(1);
            end
            if (idx_ff < fill_ff) begin
               rd_en   = 1'b1;
               idx_in  = idx_ff + ONE_F;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  fill_in  = fill_ff - ONE_F;
                  state_in = ust_pkg::BK_RESP;
               end
            end
         end
         ust_pkg::BK_RESP: begin
            if (!rsp_stall) begin
               state_in = ust_pkg::BK_IDLE;
            end
         end
         default: state_in = ust_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ust_pkg::BK_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      cmp_ff    <= cmp_in;
      dst_ff    <= dst_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   assign fill_ext   = EXT_W'(fill_ff);
   assign rsp_valid  = (state_ff == ust_pkg::BK_RESP);
   assign rsp_status = status_ff;
   assign rsp_found  = found_ff;
   assign rsp_count  = fill_ext[ust_pkg::COUNT_W-1:0];

`ifndef SYNTHESIS
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_F)
      else $error("Fill count exceeds the table depth.");

   a_full_not_found : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status_ff == ust_pkg::ST_FULL) |-> !found_ff)
      else $error("A refused insert reports the value as present.");

   a_shift_is_delete : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ust_pkg::BK_SHIFT) |-> (op_ff == ust_pkg::OP_DELETE))
      else $error("Entries shift for an operation other than delete.");

   a_fill_moves_on_write : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ust_pkg::BK_SCAN) && wr_en |=> (fill_ff == $past(fill_ff) + ONE_F))
      else $error("An insert write did not grow the fill count.");

   a_delete_shrinks : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ust_pkg::BK_SHIFT) && (state_in == ust_pkg::BK_RESP)
      |=> (fill_ff == $past(fill_ff) - ONE_F))
      else $error("A delete did not shrink the fill count.");
`endif

endmodule

// File: hdl/unique_set_table_unit.sv
// The back end handles one item at a time: it takes the next item from the queue only after
// the response beat for the last one is accepted. Each request scans the entries through the
// single read port of the entry memory, and a delete also shifts the later entries through it.
// A two-entry queue takes new request beats while a response waits on the output.
// Synchronous reset empties the table and the queue; the entry memory itself is not cleared.
module unique_set_table_unit #(
   parameter int unsigned DEPTH = ust_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ust_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [ust_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ust_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_found,
   output logic [ust_pkg::COUNT_W-1:0]        rsp_count
);

   ust_pkg::queue_out_type q_out;
   logic                   q_pop;

   ust_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind (req_kind),
      .req_value(req_value),
      .q_out    (q_out),
      .q_pop    (q_pop)
   );

   ust_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found (rsp_found),
      .rsp_count (rsp_count)
   );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned SET_DEPTH    = ust_pkg::DEPTH_DEFAULT;
   localparam int unsigned RANDOM_ITEMS = 1022;
   localparam int unsigned POOL_SIZE    = 20;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 100;

   localparam logic [ust_pkg::KIND_W-1:0] KIND_LOOKUP = 2'd2;
   localparam logic [ust_pkg::KIND_W-1:0] KIND_SPARE  = 2'd3;

   typedef struct packed {
      ust_pkg::status_type         status;
      logic                        found;
      logic [ust_pkg::COUNT_W-1:0] count;
   } outcome_type;

   typedef struct packed {
      logic [ust_pkg::KIND_W-1:0]  kind;
      logic [ust_pkg::VALUE_W-1:0] value;
      logic                        typed;
      outcome_type                 outcome;
   } step_row_type;

   localparam step_row_type DIRECTED [28] = '{
      '{KIND_LOOKUP, 32'h0000_0000, 1'b1, '{ust_pkg::ST_ABSENT, 1'b0, 5'd0}},
      '{ust_pkg::KIND_DELETE, 32'h0000_0000, 1'b1, '{ust_pkg::ST_ABSENT, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'h8000_0000, 1'b1, '{ust_pkg::ST_OK,     1'b0, 5'd1}},
      '{ust_pkg::KIND_INSERT, 32'h7fff_ffff, 1'b1, '{ust_pkg::ST_OK,     1'b0, 5'd2}},
      '{ust_pkg::KIND_INSERT, 32'h8000_0000, 1'b1, '{ust_pkg::ST_DUP,    1'b1, 5'd2}},
      '{KIND_LOOKUP, 32'h7fff_ffff, 1'b1, '{ust_pkg::ST_OK,     1'b1, 5'd2}},
      '{ust_pkg::KIND_INSERT, 32'h0000_0000, 1'b1, '{ust_pkg::ST_OK,     1'b0, 5'd3}},
      '{ust_pkg::KIND_INSERT, 32'hffff_ffff, 1'b1, '{ust_pkg::ST_OK,     1'b0, 5'd4}},
      '{ust_pkg::KIND_DELETE, 32'h8000_0000, 1'b1, '{ust_pkg::ST_OK,     1'b1, 5'd3}},
      '{KIND_SPARE,  32'h8000_0000, 1'b1, '{ust_pkg::ST_ABSENT, 1'b0, 5'd3}},
      '{KIND_SPARE,  32'h0000_0000, 1'b1, '{ust_pkg::ST_OK,     1'b1, 5'd3}},
      '{ust_pkg::KIND_INSERT, 32'd1,  1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd2,  1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd3,  1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd4,  1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd5,  1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd6,  1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd7,  1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd8,  1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd9,  1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd10, 1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd11, 1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd12, 1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd13, 1'b0, '{ust_pkg::ST_OK, 1'b0, 5'd0}},
      '{ust_pkg::KIND_INSERT, 32'd14,        1'b1, '{ust_pkg::ST_FULL, 1'b0, 5'd16}},
      '{ust_pkg::KIND_INSERT, 32'hffff_ffff, 1'b1, '{ust_pkg::ST_DUP,  1'b1, 5'd16}},
      '{ust_pkg::KIND_DELETE, 32'd13,        1'b1, '{ust_pkg::ST_OK,   1'b1, 5'd15}},
      '{ust_pkg::KIND_DELETE, 32'h7fff_ffff, 1'b1, '{ust_pkg::ST_OK,   1'b1, 5'd14}}
   };

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [ust_pkg::KIND_W-1:0]         req_kind  = '0;
   logic signed [ust_pkg::VALUE_W-1:0] req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [ust_pkg::STATUS_W-1:0]       rsp_status;
   logic                               rsp_found;
   logic [ust_pkg::COUNT_W-1:0]        rsp_count;

   logic [ust_pkg::VALUE_W-1:0] set_entries [SET_DEPTH];
   int unsigned                 set_fill = 0;

   step_row_type stimulus [$];
   outcome_type  pending_outcomes [$];
   outcome_type  predicted;
   outcome_type  oldest;
   step_row_type row;
   logic [ust_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
   int unsigned issued   = 0;
   int unsigned accepted = 0;
   int unsigned received = 0;
   int unsigned mismatches = 0;
   int unsigned cycles   = 0;

   unique_set_table_unit #(.DEPTH(SET_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_found  (rsp_found),
      .rsp_count  (rsp_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic outcome_type set_update(logic [ust_pkg::KIND_W-1:0] kind,
                                              logic [ust_pkg::VALUE_W-1:0] value);
      int unsigned pos;
      logic        present;
      outcome_type result;
      pos = set_fill;
      for (int unsigned i = 0; i < set_fill; i++) begin
         if (set_entries[i] == value && pos == set_fill) begin
            pos = i;
         end
      end
      present = pos < set_fill;
      case (kind)
         ust_pkg::KIND_INSERT: begin
            if (present) begin
               result.status = ust_pkg::ST_DUP;
            end else if (set_fill >= SET_DEPTH) begin
               result.status = ust_pkg::ST_FULL;
            end else begin
               set_entries[set_fill] = value;
               set_fill++;
               result.status = ust_pkg::ST_OK;
            end
         end
         ust_pkg::KIND_DELETE: begin
            if (present) begin
               for (int unsigned i = pos; i + 1 < set_fill; i++) begin
                  set_entries[i] = set_entries[i + 1];
               end
               set_fill--;
               result.status = ust_pkg::ST_OK;
            end else begin
               result.status = ust_pkg::ST_ABSENT;
            end
         end
         default: begin
            result.status = present ? ust_pkg::ST_OK : ust_pkg::ST_ABSENT;
         end
      endcase
      result.found = present;
      result.count = set_fill[ust_pkg::COUNT_W-1:0];
      return result;
   endfunction

   // The sender idles more once a third of the beats are out, and not at all in the last third.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = set_update(req_kind, req_value);
            row = stimulus[issued - 1];
            pending_outcomes.insert(pending_outcomes.size(),
                                    row.typed ? row.outcome : predicted);
            accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (issued < stimulus.size() && $urandom_range(99) >=
                (issued * 3 < stimulus.size() ? 33 :
                 issued * 3 < stimulus.size() * 2 ? 62 : 0)) begin
               req_valid <= 1'b1;
               req_kind  <= stimulus[issued].kind;
               req_value <= stimulus[issued].value;
               issued++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         received++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response beat with nothing expected (status %0d found %0d count %0d)",
                     $time, rsp_status, rsp_found, rsp_count);
            mismatches++;
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_status !== oldest.status) begin
               $display("%0t: status expected %0d got %0d", $time, oldest.status, rsp_status);
               mismatches++;
            end
            if (rsp_found !== oldest.found) begin
               $display("%0t: found expected %0d got %0d", $time, oldest.found, rsp_found);
               mismatches++;
            end
            if (rsp_count !== oldest.count) begin
               $display("%0t: count expected %0d got %0d", $time, oldest.count, rsp_count);
               mismatches++;
            end
         end
      end
      rsp_stall <= $urandom_range(99) <
                   (received * 3 < stimulus.size() ? 62 :
                    received * 3 < stimulus.size() * 2 ? 33 : 0);
   end

   initial begin
      int unsigned pick;
      logic [ust_pkg::KIND_W-1:0] kind;
      logic [ust_pkg::VALUE_W-1:0] value;
      step_row_type item;

      foreach (DIRECTED[i]) begin
         stimulus.insert(stimulus.size(), DIRECTED[i]);
      end

      // A small pool of values keeps the table busy with hits, refusals and shifts.
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      for (int unsigned i = 4; i < POOL_SIZE; i++) begin
         value_pool[i] = $urandom;
      end

      // Stretches that favour inserts alternate with stretches that favour deletes.
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(99);
         if ((i / 40) % 2 == 0) begin
            kind = pick < 55 ? ust_pkg::KIND_INSERT : pick < 75 ? ust_pkg::KIND_DELETE :
                   pick < 95 ? KIND_LOOKUP : KIND_SPARE;
         end else begin
            kind = pick < 25 ? ust_pkg::KIND_INSERT : pick < 60 ? ust_pkg::KIND_DELETE :
                   pick < 95 ? KIND_LOOKUP : KIND_SPARE;
         end
         value = ($urandom_range(9) == 0) ? $urandom : value_pool[$urandom_range(POOL_SIZE - 1)];
         item = '{kind, value, 1'b0, '{ust_pkg::ST_OK, 1'b0, '0}};
         stimulus.insert(stimulus.size(), item);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (!(accepted == stimulus.size() && pending_outcomes.size() == 0)
             && cycles < CYCLE_LIMIT) begin
         @(negedge clock);
         cycles++;
      end

      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d beats outstanding", $time, pending_outcomes.size());
         $display("tb: failure");
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("tb: success");
         end else begin
            $display("tb: failure");
         end
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/ust_pkg.sv
hdl/ust_ram.sv
hdl/ust_front.sv
hdl/ust_back.sv
hdl/unique_set_table_unit.sv
test/testbench.sv
